FILE: hw/rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg: shared constants and types for the Life row stream block
// Tile geometry, lane split, stream widths and the result tag type.
// ----------------------------------------------------------------------------
package lrs_pkg;

    // Tile edge length in cells (8 to 64)
    localparam int TILE_SIZE  = 64;
    // Fixed field widths of the stream payloads
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;

    // Lane split: each lane evaluates LANE_W adjacent cells
    localparam int NUM_LANES  = 8;
    localparam int LANE_W     = (TILE_SIZE + NUM_LANES - 1) / NUM_LANES;
    localparam int PAD_W      = NUM_LANES * LANE_W;
    // Stored row: west bit, cells, east bit, zero padding above
    localparam int EXT_W      = PAD_W + 2;

    // Rows per frame: south halo, tile rows, north halo
    localparam int FRAME_ROWS = TILE_SIZE + 2;
    localparam int SEEN_W     = $clog2(FRAME_ROWS + 1);

    // Neighbor count width (0..8)
    localparam int CNT_W      = 4;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic             last_row;
    } lrs_tag_t;

endpackage

FILE: hw/rtl/lrs_lane.sv
// ----------------------------------------------------------------------------
// lrs_lane: B3/S23 rule for one slice of adjacent cells
// Counts the eight neighbors of each cell in the slice and applies the rule.
// Each row input carries the slice plus one cell on either side.
// ----------------------------------------------------------------------------
module lrs_lane (
    input  logic [lrs_pkg::LANE_W+1:0] south_bits,
    input  logic [lrs_pkg::LANE_W+1:0] mid_bits,
    input  logic [lrs_pkg::LANE_W+1:0] north_bits,
    output logic [lrs_pkg::LANE_W-1:0] next_bits
);

    logic [lrs_pkg::CNT_W-1:0] cnt [lrs_pkg::LANE_W];

    always_comb begin
        for (int i = 0; i < lrs_pkg::LANE_W; i++) begin
            // bit i is the west neighbor, bit i+1 the cell itself, bit i+2 the east
            cnt[i] = lrs_pkg::CNT_W'(south_bits[i]) + lrs_pkg::CNT_W'(south_bits[i+1])
                   + lrs_pkg::CNT_W'(south_bits[i+2]) + lrs_pkg::CNT_W'(mid_bits[i])
                   + lrs_pkg::CNT_W'(mid_bits[i+2]) + lrs_pkg::CNT_W'(north_bits[i])
                   + lrs_pkg::CNT_W'(north_bits[i+1]) + lrs_pkg::CNT_W'(north_bits[i+2]);
            next_bits[i] = (cnt[i] == lrs_pkg::CNT_W'(3))
                         || (mid_bits[i+1] && (cnt[i] == lrs_pkg::CNT_W'(2)));
        end
    end

endmodule

FILE: hw/rtl/lrs_merge.sv
// ----------------------------------------------------------------------------
// lrs_merge: joins the lane results into one output item
// Concatenates the lane slices, trims the padding above the tile and holds
// the item in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module lrs_merge (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic [lrs_pkg::NUM_LANES-1:0][lrs_pkg::LANE_W-1:0] lane_bits,
    input  lrs_pkg::lrs_tag_t                              in_tag,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [lrs_pkg::M_TDATA_W-1:0]                  m_tdata, // next_row, row_index
    output logic                                           m_tlast  // last_row
);

    typedef struct packed {
        logic [lrs_pkg::ROW_W-1:0] next_row;
        lrs_pkg::lrs_tag_t         tag;
    } lrs_item_t;

    logic [lrs_pkg::PAD_W-1:0] flat;
    lrs_item_t                 in_item;
    lrs_item_t                 main_reg, main_next;
    lrs_item_t                 skid_reg, skid_next;
    logic                      main_valid_reg, main_valid_next;
    logic                      skid_valid_reg, skid_valid_next;
    logic                      push, pop;

    assign flat             = lane_bits;
    assign in_item.next_row = lrs_pkg::ROW_W'(flat[lrs_pkg::TILE_SIZE-1:0]);
    assign in_item.tag      = in_tag;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && m_tready;

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (push) begin
            // skid is empty here; park the item only if the output stays busy
            if (main_valid_reg && !pop) begin
                skid_next       = in_item;
                skid_valid_next = 1'b1;
            end else begin
                main_next       = in_item;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {(lrs_pkg::M_TDATA_W - lrs_pkg::ROW_W - lrs_pkg::IDX_W)'(0),
                       main_reg.tag.row_index, main_reg.next_row};
    assign m_tlast  = main_reg.tag.last_row;

`ifndef NO_ASSERTIONS
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_stall_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && main_valid_reg && !m_tready) |=> (skid_valid_reg && main_valid_reg))
        else $error("item taken during an output stall was not parked");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid register did not move into the output register");
`endif

endmodule

FILE: hw/rtl/life_row_stream_b3s23.sv
// ----------------------------------------------------------------------------
// life_row_stream_b3s23: one Life generation (B3/S23) of a tile, row by row
// Keeps a two-row window and evaluates the middle row in parallel lanes.
// ----------------------------------------------------------------------------
// Send each frame as TILE_SIZE+2 rows from south to north: a south halo row
// (tagged with frame_start in s_tuser), the tile rows, then a north halo row;
// feed zeros for a missing neighbor tile. Rows may follow back to back while
// s_tready stays high. From the third row of a frame on, each row yields one
// output item holding the next generation of the row before it; the item is
// registered in the output register, or in the skid register while the output
// is held up. Rows after the north halo are dropped until the next frame_start.
// The first row after reset starts a frame even without frame_start.
// The output has a skid register, so s_tready only drops after two items
// are held up by m_tready.
module life_row_stream_b3s23 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lrs_pkg::S_TDATA_W-1:0] s_tdata,  // row_bits, east_bit, west_bit
    input  logic                          s_tuser,  // frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lrs_pkg::M_TDATA_W-1:0] m_tdata,  // next_row, row_index
    output logic                          m_tlast   // last_row
);

    logic [lrs_pkg::EXT_W-1:0]  older_reg, older_next;
    logic [lrs_pkg::EXT_W-1:0]  middle_reg, middle_next;
    logic [lrs_pkg::EXT_W-1:0]  cur_row;
    logic [lrs_pkg::SEEN_W-1:0] rows_seen_reg, rows_seen_next;
    logic [lrs_pkg::SEEN_W-1:0] seen_eff;
    logic [lrs_pkg::SEEN_W-1:0] idx;
    logic                       accept, live, emit;
    lrs_pkg::lrs_tag_t          tag;
    logic [lrs_pkg::NUM_LANES-1:0][lrs_pkg::LANE_W-1:0] lane_bits;

    // Widened row: west bit at 0, cells from 1, east bit just above the tile
    always_comb begin
        cur_row                          = '0;
        cur_row[0]                       = s_tdata[lrs_pkg::ROW_W+1];
        cur_row[lrs_pkg::TILE_SIZE:1]    = s_tdata[lrs_pkg::TILE_SIZE-1:0];
        cur_row[lrs_pkg::TILE_SIZE+1]    = s_tdata[lrs_pkg::ROW_W];
    end

    assign accept   = s_tvalid && s_tready;
    assign seen_eff = s_tuser ? '0 : rows_seen_reg;
    assign live     = seen_eff < lrs_pkg::SEEN_W'(lrs_pkg::FRAME_ROWS);
    assign emit     = live && (seen_eff >= lrs_pkg::SEEN_W'(2));
    assign idx      = seen_eff - lrs_pkg::SEEN_W'(2);

    assign tag.row_index = lrs_pkg::IDX_W'(idx);
    assign tag.last_row  = (idx == lrs_pkg::SEEN_W'(lrs_pkg::TILE_SIZE - 1));

    always_comb begin
        older_next     = older_reg;
        middle_next    = middle_reg;
        rows_seen_next = rows_seen_reg;
        if (accept && live) begin
            older_next     = middle_reg;
            middle_next    = cur_row;
            rows_seen_next = seen_eff + lrs_pkg::SEEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_seen_reg <= '0;
        end else begin
            rows_seen_reg <= rows_seen_next;
        end
        older_reg  <= older_next;
        middle_reg <= middle_next;
    end

    for (genvar l = 0; l < lrs_pkg::NUM_LANES; l++) begin : g_lane
        lrs_lane u_lane (
            .south_bits (older_reg[l*lrs_pkg::LANE_W +: lrs_pkg::LANE_W+2]),
            .mid_bits   (middle_reg[l*lrs_pkg::LANE_W +: lrs_pkg::LANE_W+2]),
            .north_bits (cur_row[l*lrs_pkg::LANE_W +: lrs_pkg::LANE_W+2]),
            .next_bits  (lane_bits[l])
        );
    end

    lrs_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_bits (lane_bits),
        .in_tag    (tag),
        .in_valid  (s_tvalid && emit),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_seen_reg <= lrs_pkg::SEEN_W'(lrs_pkg::FRAME_ROWS))
        else $error("row counter ran past the frame length");

    a_out_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(accept))
        else $error("output item appeared without an input item");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tdata[lrs_pkg::ROW_W +: lrs_pkg::IDX_W] == lrs_pkg::IDX_W'(lrs_pkg::TILE_SIZE-1)))
        else $error("last row flag on a row other than the northmost");
`endif

endmodule
